// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the LZ4 block decompressor.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold on the same edge.
`define LZ4D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lz4d implication check failed");

// The condition must never hold on any edge.
`define LZ4D_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lz4d forbidden condition seen");

`endif

// ----- hw/rtl/lz4d_pkg.sv -----
// ----------------------------------------------------------------------------
// lz4d_pkg
// Shared types and constants of the LZ4 block decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lz4d_pkg;

  localparam int HIST_AW    = 16;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int LEN_W      = 24;
  localparam int CNT_W      = HIST_AW + 1;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_DRAIN = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LENGTH  = 3'd1;
  localparam logic [2:0] ST_OFFSET  = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  localparam logic [7:0] EXT_BYTE       = 8'hFF;
  localparam logic [2:0] MATCH_LEN_BASE = 3'd4;

  // What the back end has to do with a queued transaction.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LIT,
    KIND_COPY
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          lit_byte;
    logic [HIST_AW-1:0]  rd_addr;
    logic [HIST_AW-1:0]  wr_addr;
    logic                match_pending;
    logic                block_done;
    logic [2:0]          status;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Result word as it leaves on out_tdata, lowest field last.
  typedef struct packed {
    logic [2:0] pad;
    logic [2:0] status;
    logic       block_done;
    logic       match_pending;
    logic [7:0] data_byte;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lz4_block_decompressor.sv -----
// ----------------------------------------------------------------------------
// lz4_block_decompressor
// LZ4 block decoder, 64 KiB history window, one transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while its job queue has room,
// each a compressed byte, a drain tick for a pending match or a start of a new
// block, and returns exactly one result transaction for each, in order. A result
// passes through the queue, the back end's read stage and its output register
// before it is offered. The parser updates its sequence state in the cycle of
// acceptance and passes a job through a four-entry queue to the back end, which
// owns the history memory: one read and one write per cycle while the output
// side takes results, so a match byte is produced on every drain tick during a
// match. The input is held off only while that queue is full, which happens
// when the output side stalls. The history memory needs no clearing after reset,
// and the length limit may be written at any time the block is idle.
`default_nettype none
`include "assert_macros.svh"

module lz4_block_decompressor (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lz4d_pkg::LEN_W-1:0]  cfg_wr_data,   // length_limit
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,      // [7:0] in_byte
  input  wire logic [1:0]                  in_tuser,      // [1:0] opcode
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [7:0] out_byte, [8] match_pending, [9] block_done, [12:10] status, rest 0
  output logic [15:0]                      out_tdata,
  output logic                             out_tuser      // [0] byte_valid
);
  import lz4d_pkg::*;

  logic      push;
  qent_t     push_data;
  logic      pop;
  qent_t     pop_data;
  qstat_t    q_stat;
  out_word_t out_word;

  lz4d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  lz4d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  lz4d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_word),
    .out_user  (out_tuser)
  );

  assign out_tdata = out_word;

  // A result without a decoded byte carries a zero byte.
  `LZ4D_ASSERT_IMP(a_no_byte_zero, out_tvalid && !out_tuser, out_word.data_byte == 8'h00)
  // A refused byte never produces output data.
  `LZ4D_ASSERT_IMP(a_refused_no_byte, out_tvalid && out_word.status == ST_REFUSED, !out_tuser)
  // A finished block carries no sticky error.
  `LZ4D_ASSERT_IMP(a_done_clean, out_tvalid && out_word.block_done,
                   out_word.status == ST_OK || out_word.status == ST_REFUSED)
  // The decoder cannot be both draining a match and finished.
  `LZ4D_ASSERT_NEVER(a_done_not_pending,
                     out_tvalid && out_word.block_done && out_word.match_pending)

endmodule

`default_nettype wire

// ----- hw/rtl/lz4d_front.sv -----
// ----------------------------------------------------------------------------
// lz4d_front
// Parses the compressed stream and keeps the sequence state, one transaction
// per cycle while the queue has room, and queues a back-end job for each.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lz4d_pkg::LEN_W-1:0]  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic [7:0]                  in_byte,
  input  wire logic                        in_last,
  input  wire lz4d_pkg::qstat_t            q_stat,
  output logic                             push,
  output lz4d_pkg::qent_t                  push_data
);
  import lz4d_pkg::*;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LIT_EXT,
    PH_LITERALS,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATCH_EXT,
    PH_DRAIN,
    PH_HALT
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         nib_r, nib_nxt;
  logic [LEN_W-1:0]   lit_rem_r, lit_rem_nxt;
  logic [15:0]        off_r, off_nxt;
  logic [LEN_W-1:0]   mrem_r, mrem_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]   prod_r, prod_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [LEN_W-1:0]   lim_r;

  logic               accept;
  logic               emit;
  logic               refused;
  kind_t              kind;
  logic [LEN_W:0]     lit_sum;
  logic [LEN_W+1:0]   m_sum;
  logic [LEN_W+1:0]   m_sum4;
  logic [15:0]        off_full;
  logic [LEN_W-1:0]   short_len;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign lit_sum   = (LEN_W+1)'(lit_rem_r) + (LEN_W+1)'(in_byte);
  assign m_sum     = (LEN_W+2)'(mrem_r) + (LEN_W+2)'(in_byte);
  assign m_sum4    = m_sum + (LEN_W+2)'(MATCH_LEN_BASE);
  assign off_full  = {in_byte, off_r[7:0]};
  assign short_len = LEN_W'(nib_r) + LEN_W'(MATCH_LEN_BASE);

  always_comb begin
    phase_nxt   = phase_r;
    nib_nxt     = nib_r;
    lit_rem_nxt = lit_rem_r;
    off_nxt     = off_r;
    mrem_nxt    = mrem_r;
    err_nxt     = err_r;
    kind        = KIND_NONE;
    emit        = 1'b0;
    refused     = 1'b0;

    unique case (in_op)
      OP_START: begin
        phase_nxt   = PH_TOKEN;
        nib_nxt     = '0;
        lit_rem_nxt = '0;
        off_nxt     = '0;
        mrem_nxt    = '0;
        err_nxt     = ST_OK;
      end
      OP_DRAIN: begin
        if (phase_r == PH_DRAIN) begin
          kind = KIND_COPY;
          emit = 1'b1;
          if (mrem_r != '0) begin
            mrem_nxt = mrem_r - 1'b1;
          end
          if (mrem_r <= LEN_W'(1)) begin
            phase_nxt = PH_TOKEN;
          end
        end
      end
      OP_BYTE: begin
        if (phase_r == PH_HALT || phase_r == PH_DRAIN) begin
          refused = 1'b1;
        end else begin
          unique case (phase_r)
            PH_TOKEN: begin
              nib_nxt     = in_byte[3:0];
              lit_rem_nxt = LEN_W'(in_byte[7:4]);
              if (in_byte[7:4] == 4'hF) begin
                phase_nxt = PH_LIT_EXT;
              end else if (LEN_W'(in_byte[7:4]) > lim_r) begin
                phase_nxt = PH_HALT;
                err_nxt   = ST_LENGTH;
              end else if (in_byte[7:4] == 4'h0) begin
                phase_nxt = PH_OFF_LO;
              end else begin
                phase_nxt = PH_LITERALS;
              end
              // A token with no literals may legally close the block.
              if (phase_nxt != PH_HALT && in_last) begin
                phase_nxt = PH_HALT;
                if (in_byte[7:4] != 4'h0) begin
                  err_nxt = ST_TRUNC;
                end
              end
            end
            PH_LIT_EXT: begin
              if (lit_sum > (LEN_W+1)'(lim_r)) begin
                phase_nxt = PH_HALT;
                err_nxt   = ST_LENGTH;
              end else begin
                lit_rem_nxt = lit_sum[LEN_W-1:0];
                if (in_byte != EXT_BYTE) begin
                  phase_nxt = PH_LITERALS;
                end
                if (in_last) begin
                  phase_nxt = PH_HALT;
                  err_nxt   = ST_TRUNC;
                end
              end
            end
            PH_LITERALS: begin
              kind = KIND_LIT;
              emit = 1'b1;
              if (lit_rem_r != '0) begin
                lit_rem_nxt = lit_rem_r - 1'b1;
              end
              if (lit_rem_r <= LEN_W'(1)) begin
                phase_nxt = in_last ? PH_HALT : PH_OFF_LO;
              end else if (in_last) begin
                phase_nxt = PH_HALT;
                err_nxt   = ST_TRUNC;
              end
            end
            PH_OFF_LO: begin
              off_nxt   = {8'h00, in_byte};
              phase_nxt = PH_OFF_HI;
              if (in_last) begin
                phase_nxt = PH_HALT;
                err_nxt   = ST_TRUNC;
              end
            end
            PH_OFF_HI: begin
              off_nxt = off_full;
              if (off_full == '0 || CNT_W'(off_full) > prod_r) begin
                phase_nxt = PH_HALT;
                err_nxt   = ST_OFFSET;
              end else if (nib_r == 4'hF) begin
                mrem_nxt  = LEN_W'(15);
                phase_nxt = PH_MATCH_EXT;
                if (LEN_W'(19) > lim_r) begin
                  phase_nxt = PH_HALT;
                  err_nxt   = ST_LENGTH;
                end else if (in_last) begin
                  phase_nxt = PH_HALT;
                  err_nxt   = ST_TRUNC;
                end
              end else begin
                mrem_nxt = short_len;
                if (short_len > lim_r) begin
                  phase_nxt = PH_HALT;
                  err_nxt   = ST_LENGTH;
                end else if (in_last) begin
                  phase_nxt = PH_HALT;
                  err_nxt   = ST_TRUNC;
                end else begin
                  phase_nxt = PH_DRAIN;
                end
              end
            end
            PH_MATCH_EXT: begin
              if (m_sum4 > (LEN_W+2)'(lim_r)) begin
                phase_nxt = PH_HALT;
                err_nxt   = ST_LENGTH;
              end else if (in_last) begin
                mrem_nxt  = m_sum[LEN_W-1:0];
                phase_nxt = PH_HALT;
                err_nxt   = ST_TRUNC;
              end else if (in_byte != EXT_BYTE) begin
                mrem_nxt  = m_sum4[LEN_W-1:0];
                phase_nxt = PH_DRAIN;
              end else begin
                mrem_nxt = m_sum[LEN_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    wp_nxt   = wp_r;
    prod_nxt = (in_op == OP_START) ? '0 : prod_r;
    if (emit) begin
      wp_nxt = wp_r + 1'b1;
      if (prod_r != CNT_W'(HIST_DEPTH)) begin
        prod_nxt = prod_r + 1'b1;
      end
    end
  end

  always_comb begin
    push_data.kind          = kind;
    push_data.lit_byte      = in_byte;
    push_data.rd_addr       = wp_r - HIST_AW'(off_r);
    push_data.wr_addr       = wp_r;
    push_data.match_pending = (phase_nxt == PH_DRAIN);
    push_data.block_done    = (phase_nxt == PH_HALT) && (err_nxt == ST_OK);
    push_data.status        = refused ? ST_REFUSED : err_nxt;
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TOKEN;
      nib_r     <= '0;
      lit_rem_r <= '0;
      off_r     <= '0;
      mrem_r    <= '0;
      wp_r      <= '0;
      prod_r    <= '0;
      err_r     <= ST_OK;
      lim_r     <= '1;
    end else begin
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r   <= phase_nxt;
        nib_r     <= nib_nxt;
        lit_rem_r <= lit_rem_nxt;
        off_r     <= off_nxt;
        mrem_r    <= mrem_nxt;
        wp_r      <= wp_nxt;
        prod_r    <= prod_nxt;
        err_r     <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lz4d_fifo.sv -----
// ----------------------------------------------------------------------------
// lz4d_fifo
// Short job queue between the parser and the history back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lz4d_pkg::qent_t  push_data,
  input  wire logic             pop,
  output lz4d_pkg::qent_t       pop_data,
  output lz4d_pkg::qstat_t      stat
);
  import lz4d_pkg::*;

  qent_t           q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign pop_data   = q_mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lz4d_back.sv -----
// ----------------------------------------------------------------------------
// lz4d_back
// Executes queued jobs: reads match bytes from the history window, writes
// every produced byte back into it and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lz4d_pkg::qstat_t q_stat,
  output logic                  pop,
  input  wire lz4d_pkg::qent_t  pop_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lz4d_pkg::out_word_t   out_data,
  output logic                  out_user
);
  import lz4d_pkg::*;

  logic [7:0]  hist_mem [HIST_DEPTH];

  logic        s1_valid_r;
  qent_t       s1_ent_r;
  logic [7:0]  rd_data_r;
  logic        fwd_hit_r;
  logic [7:0]  fwd_byte_r;
  logic        out_valid_r;
  out_word_t   out_data_r;
  logic        out_user_r;

  logic        s1_adv;
  logic        s1_write;
  logic        hit;
  logic [7:0]  s1_byte;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign pop      = !q_stat.empty && (!s1_valid_r || s1_adv);
  assign s1_write = s1_adv && (s1_ent_r.kind != KIND_NONE);

  // A read issued on the same edge as the previous byte is written would see
  // stale data, so that byte is carried alongside instead.
  assign hit = s1_write && (s1_ent_r.wr_addr == pop_data.rd_addr);

  always_comb begin
    case (s1_ent_r.kind)
      KIND_LIT:  s1_byte = s1_ent_r.lit_byte;
      KIND_COPY: s1_byte = fwd_hit_r ? fwd_byte_r : rd_data_r;
      default:   s1_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      hist_mem[s1_ent_r.wr_addr] <= s1_byte;
    end
    if (pop) begin
      rd_data_r <= hist_mem[pop_data.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ent_r   <= pop_data;
      fwd_hit_r  <= hit;
      fwd_byte_r <= s1_byte;
    end
    if (s1_adv) begin
      out_data_r.pad           <= '0;
      out_data_r.status        <= s1_ent_r.status;
      out_data_r.block_done    <= s1_ent_r.block_done;
      out_data_r.match_pending <= s1_ent_r.match_pending;
      out_data_r.data_byte     <= s1_byte;
      out_user_r               <= (s1_ent_r.kind != KIND_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

endmodule

`default_nettype wire
